@@ design/tiflf_pkg.sv @@
// shared types, byte codes and helpers for the telnet iac filter line framer
package tiflf_pkg;

	localparam int MAX_RES = 3;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] BYTE_IAC  = 8'd255;
	localparam logic [7:0] BYTE_WILL = 8'd251;
	localparam logic [7:0] BYTE_WONT = 8'd252;
	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] BYTE_CR   = 8'd13;
	localparam logic [7:0] BYTE_LF   = 8'd10;
	localparam logic [7:0] BYTE_NUL  = 8'd0;
	localparam logic [7:0] BYTE_SUB  = 8'd63;

	localparam logic DEST_USER = 1'b0;
	localparam logic DEST_PEER = 1'b1;

	typedef enum logic [2:0] {
		PH_TEXT = 3'b001,
		PH_IAC  = 3'b010,
		PH_CMD  = 3'b100
	} phase_t;

	typedef struct packed {
		logic       dest;
		logic [7:0] out_byte;
		logic       has_byte;
		logic       line_end;
		logic       echo_local;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0]     cnt;
		res_t [MAX_RES-1:0] res;
	} push_t;

	function automatic res_t mk_res(logic dest, logic [7:0] b, logic has, logic le);
		res_t r;
		r.dest       = dest;
		r.out_byte   = has ? b : 8'd0;
		r.has_byte   = has;
		r.line_end   = le;
		r.echo_local = 1'b0;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

@@ design/telnet_iac_filter_line_framer_top.sv @@
// top level of the telnet iac filter line framer
// Takes one received byte per cycle with its chunk-end flag, strips every
// three-byte sequence that starts with 255, answers WILL ECHO and WONT ECHO
// toward the peer and frames the remaining text into lines. A byte is
// registered on entry and decoded in the next cycle into zero to three result
// items, which go into a four-entry queue that drains one item per cycle while
// out_stall is low. Input is taken every cycle as long as the queue has room
// for the pending byte's results; a negotiation reply (three items) or a byte
// that flushes a held CR (two items) costs extra output cycles, so the sustained
// input rate is one byte per cycle for plain text when the output does not stall
// and is bounded by the single output port otherwise.
module telnet_iac_filter_line_framer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       chunk_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       dest,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       line_end,
	output logic       echo_local,
	output logic       last
);

	tiflf_pkg::push_t            push;
	logic [tiflf_pkg::QAW:0]     q_free;
	tiflf_pkg::res_t             head;

	tiflf_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.chunk_end (chunk_end),
		.q_free    (q_free),
		.push      (push)
	);

	tiflf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_free    (q_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign dest       = head.dest;
	assign out_byte   = head.out_byte;
	assign has_byte   = head.has_byte;
	assign line_end   = head.line_end;
	assign echo_local = head.echo_local;
	assign last       = head.last;

endmodule

@@ design/tiflf_decode.sv @@
// input register, filter state and per-item result generation
module tiflf_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        chunk_end,
	input  logic [tiflf_pkg::QAW:0]     q_free,
	output tiflf_pkg::push_t            push
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                ce_s1;

	tiflf_pkg::phase_t   phase_q, phase_n;
	logic [7:0]          held_cmd_q, held_n;
	logic                pcr_q, pcr_n;
	logic                lopen_q, lopen_n;
	logic                echo_q, echo_n;

	tiflf_pkg::res_t [tiflf_pkg::MAX_RES-1:0] r;
	logic [1:0]          n;
	logic [7:0]          reply;
	logic [7:0]          bb;
	logic                close_hit;
	tiflf_pkg::res_t     close_res;
	logic                space_ok;
	logic                consume;

	assign space_ok = {1'b0, n} <= q_free;
	assign consume  = valid_s1 && space_ok;
	assign in_stall = valid_s1 && !space_ok;

	// closing an open line: held cr carries the close, else a bare marker
	assign close_hit = pcr_q || lopen_q;
	assign close_res = pcr_q
		? tiflf_pkg::mk_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_CR, 1'b1, 1'b1)
		: tiflf_pkg::mk_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_NUL, 1'b0, 1'b1);

	always_comb begin
		r       = '0;
		n       = 2'd0;
		phase_n = phase_q;
		held_n  = held_cmd_q;
		pcr_n   = pcr_q;
		lopen_n = lopen_q;
		echo_n  = echo_q;
		reply   = 8'd0;
		bb      = byte_s1;
		unique case (phase_q)
			tiflf_pkg::PH_IAC: begin
				held_n  = byte_s1;
				phase_n = tiflf_pkg::PH_CMD;
				if (ce_s1) begin
					if (close_hit) begin
						r[n] = close_res;
						n    = n + 2'd1;
					end
					pcr_n   = 1'b0;
					lopen_n = 1'b0;
				end
			end
			tiflf_pkg::PH_CMD: begin
				phase_n = tiflf_pkg::PH_TEXT;
				if (byte_s1 == tiflf_pkg::OPT_ECHO && held_cmd_q == tiflf_pkg::BYTE_WILL) begin
					reply  = tiflf_pkg::BYTE_WONT;
					echo_n = 1'b0;
				end else if (byte_s1 == tiflf_pkg::OPT_ECHO
						&& held_cmd_q == tiflf_pkg::BYTE_WONT) begin
					reply  = tiflf_pkg::BYTE_WILL;
					echo_n = 1'b1;
				end
				if (reply != 8'd0) begin
					r[0] = tiflf_pkg::mk_res(tiflf_pkg::DEST_PEER, tiflf_pkg::BYTE_IAC,
						1'b1, 1'b0);
					r[1] = tiflf_pkg::mk_res(tiflf_pkg::DEST_PEER, reply, 1'b1, 1'b0);
					// reply on a chunk end also closes the line, dropping a held cr
					r[2] = tiflf_pkg::mk_res(tiflf_pkg::DEST_PEER, tiflf_pkg::OPT_ECHO,
						1'b1, ce_s1 && close_hit);
					n = 2'd3;
					if (ce_s1) begin
						pcr_n   = 1'b0;
						lopen_n = 1'b0;
					end
				end else if (ce_s1) begin
					if (close_hit) begin
						r[n] = close_res;
						n    = n + 2'd1;
					end
					pcr_n   = 1'b0;
					lopen_n = 1'b0;
				end
			end
			default: begin
				phase_n = tiflf_pkg::PH_TEXT;
				if (byte_s1 == tiflf_pkg::BYTE_IAC) begin
					phase_n = tiflf_pkg::PH_IAC;
					if (ce_s1) begin
						if (close_hit) begin
							r[n] = close_res;
							n    = n + 2'd1;
						end
						pcr_n   = 1'b0;
						lopen_n = 1'b0;
					end
				end else if (byte_s1 == tiflf_pkg::BYTE_LF) begin
					pcr_n   = 1'b0;
					r[0]    = tiflf_pkg::mk_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_LF,
						1'b1, 1'b1);
					n       = 2'd1;
					lopen_n = 1'b0;
				end else begin
					if (byte_s1 == tiflf_pkg::BYTE_NUL) begin
						if (close_hit) begin
							r[n] = close_res;
							n    = n + 2'd1;
						end
						pcr_n   = 1'b0;
						lopen_n = 1'b0;
						bb      = tiflf_pkg::BYTE_SUB;
					end else if (pcr_q) begin
						r[n]    = tiflf_pkg::mk_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_CR,
							1'b1, 1'b0);
						n       = n + 2'd1;
						pcr_n   = 1'b0;
						lopen_n = 1'b1;
					end
					if (bb == tiflf_pkg::BYTE_CR && !ce_s1) begin
						pcr_n   = 1'b1;
						lopen_n = 1'b1;
					end else begin
						r[n]    = tiflf_pkg::mk_res(tiflf_pkg::DEST_USER, bb, 1'b1, ce_s1);
						n       = n + 2'd1;
						lopen_n = !ce_s1;
					end
				end
			end
		endcase
		for (int k = 0; k < tiflf_pkg::MAX_RES; k++) begin
			r[k].echo_local = echo_n;
			r[k].last       = (2'(k) == n - 2'd1);
		end
	end

	always_comb begin
		push.res = r;
		push.cnt = consume ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			ce_s1   <= chunk_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tiflf_pkg::PH_TEXT;
			held_cmd_q <= 8'd0;
			pcr_q      <= 1'b0;
			lopen_q    <= 1'b0;
			echo_q     <= 1'b1;
		end else if (consume) begin
			phase_q    <= phase_n;
			held_cmd_q <= held_n;
			pcr_q      <= pcr_n;
			lopen_q    <= lopen_n;
			echo_q     <= echo_n;
		end
	end

endmodule

@@ design/tiflf_queue.sv @@
// small result queue: takes up to three items a cycle, gives one while out_stall is low
module tiflf_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tiflf_pkg::push_t        push,
	output logic [tiflf_pkg::QAW:0] q_free,
	output logic                    out_valid,
	input  logic                    out_stall,
	output tiflf_pkg::res_t         head
);

	tiflf_pkg::res_t            mem_q [tiflf_pkg::QDEPTH];
	logic [tiflf_pkg::QAW-1:0]  wr_ptr_q;
	logic [tiflf_pkg::QAW-1:0]  rd_ptr_q;
	logic [tiflf_pkg::QAW:0]    cnt_q;
	logic                       pop;

	assign q_free    = (tiflf_pkg::QAW + 1)'(tiflf_pkg::QDEPTH) - cnt_q;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int k = 0; k < tiflf_pkg::MAX_RES; k++) begin
			if (2'(k) < push.cnt) begin
				mem_q[wr_ptr_q + tiflf_pkg::QAW'(k)] <= push.res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tiflf_pkg::QAW'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tiflf_pkg::QAW'(1);
			end
			cnt_q <= cnt_q + (tiflf_pkg::QAW + 1)'(push.cnt)
				- (tiflf_pkg::QAW + 1)'(pop);
		end
	end

endmodule

@@ tb/tb.sv @@
// testbench for the telnet iac filter line framer: directed table, then random streams
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int N_DIR = 27;
	localparam int N_RAND = 103;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic [7:0]      b;
		logic            ce;
		logic            typed;
		tiflf_pkg::res_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       chunk_end;
	logic       out_valid;
	logic       out_stall;
	logic       dest;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       line_end;
	logic       echo_local;
	logic       last;

	telnet_iac_filter_line_framer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.chunk_end  (chunk_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.dest       (dest),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.line_end   (line_end),
		.echo_local (echo_local),
		.last       (last)
	);

	// filter state mirror
	tiflf_pkg::phase_t m_phase;
	logic [7:0]        m_cmd;
	logic              m_cr_held;
	logic              m_line_open;
	logic              m_echo;

	tiflf_pkg::res_t step_res[$];
	tiflf_pkg::res_t filtered_q[$];
	dir_row_t        dir_rows[N_DIR];
	int              fails;
	int              in_idle_pct;
	int              out_idle_pct;
	bit              hold_req;
	int              hold_left;
	int              cyc;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic put_res(input logic d, input logic [7:0] b, input logic has,
			input logic le);
		tiflf_pkg::res_t r;
		r.dest       = d;
		r.out_byte   = has ? b : 8'd0;
		r.has_byte   = has;
		r.line_end   = le;
		r.echo_local = 1'b0;
		r.last       = 1'b0;
		if (step_res.size() < tiflf_pkg::MAX_RES)
			step_res.push_back(r);
	endtask

	task automatic close_open_line();
		if (m_cr_held)
			put_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_CR, 1'b1, 1'b1);
		else if (m_line_open)
			put_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_NUL, 1'b0, 1'b1);
		m_cr_held   = 1'b0;
		m_line_open = 1'b0;
	endtask

	task automatic frame_text(input logic [7:0] b, input logic ce);
		logic [7:0] c;
		c = b;
		if (c == tiflf_pkg::BYTE_LF) begin
			m_cr_held = 1'b0;
			put_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_LF, 1'b1, 1'b1);
			m_line_open = 1'b0;
			return;
		end
		if (c == tiflf_pkg::BYTE_NUL) begin
			close_open_line();
			c = tiflf_pkg::BYTE_SUB;
		end else if (m_cr_held) begin
			put_res(tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_CR, 1'b1, 1'b0);
			m_cr_held   = 1'b0;
			m_line_open = 1'b1;
		end
		if (c == tiflf_pkg::BYTE_CR && !ce) begin
			m_cr_held   = 1'b1;
			m_line_open = 1'b1;
			return;
		end
		put_res(tiflf_pkg::DEST_USER, c, 1'b1, ce);
		m_line_open = !ce;
	endtask

	// works out the items one accepted byte causes, into step_res
	task automatic filter_byte(input logic [7:0] b, input logic ce);
		logic [7:0] reply;
		logic       le;
		step_res.delete();
		case (m_phase)
			tiflf_pkg::PH_IAC: begin
				m_cmd   = b;
				m_phase = tiflf_pkg::PH_CMD;
				if (ce)
					close_open_line();
			end
			tiflf_pkg::PH_CMD: begin
				m_phase = tiflf_pkg::PH_TEXT;
				reply = 8'd0;
				if (b == tiflf_pkg::OPT_ECHO && m_cmd == tiflf_pkg::BYTE_WILL) begin
					reply  = tiflf_pkg::BYTE_WONT;
					m_echo = 1'b0;
				end else if (b == tiflf_pkg::OPT_ECHO && m_cmd == tiflf_pkg::BYTE_WONT) begin
					reply  = tiflf_pkg::BYTE_WILL;
					m_echo = 1'b1;
				end
				if (reply != 8'd0) begin
					le = ce && (m_line_open || m_cr_held);
					put_res(tiflf_pkg::DEST_PEER, tiflf_pkg::BYTE_IAC, 1'b1, 1'b0);
					put_res(tiflf_pkg::DEST_PEER, reply, 1'b1, 1'b0);
					put_res(tiflf_pkg::DEST_PEER, tiflf_pkg::OPT_ECHO, 1'b1, le);
					if (ce) begin
						m_cr_held   = 1'b0;
						m_line_open = 1'b0;
					end
				end else if (ce) begin
					close_open_line();
				end
			end
			default: begin
				m_phase = tiflf_pkg::PH_TEXT;
				if (b == tiflf_pkg::BYTE_IAC) begin
					m_phase = tiflf_pkg::PH_IAC;
					if (ce)
						close_open_line();
				end else begin
					frame_text(b, ce);
				end
			end
		endcase
		foreach (step_res[k]) begin
			step_res[k].echo_local = m_echo;
			step_res[k].last       = (k == step_res.size() - 1);
		end
	endtask

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic push_byte(input logic [7:0] b, input logic ce, input bit typed,
			input tiflf_pkg::res_t want);
		bit took;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		data_byte = b;
		chunk_end = ce;
		do begin
			@(posedge clk);
			took = !in_stall;
			if (took) begin
				filter_byte(b, ce);
				if (typed)
					filtered_q.push_back(want);
				else
					foreach (step_res[k])
						filtered_q.push_back(step_res[k]);
			end
			@(negedge clk);
		end while (!took);
	endtask

	task automatic push_rand(input logic [7:0] b);
		push_byte(b, $urandom_range(99) < 12, 1'b0, '0);
	endtask

	// one random piece of stream; returns the number of bytes sent
	task automatic rand_piece(output int n);
		int pick;
		int sub;
		pick = $urandom_range(99);
		n = 1;
		if (pick < 55) begin
			sub = $urandom_range(99);
			if (sub < 60)
				push_rand(8'($urandom_range(126, 32)));
			else if (sub < 72) begin
				push_rand(tiflf_pkg::BYTE_CR);
				push_rand(tiflf_pkg::BYTE_LF);
				n = 2;
			end else if (sub < 80)
				push_rand(tiflf_pkg::BYTE_CR);
			else if (sub < 87)
				push_rand(tiflf_pkg::BYTE_LF);
			else if (sub < 92)
				push_rand(tiflf_pkg::BYTE_NUL);
			else
				push_rand(8'($urandom_range(254, 0)));
		end else if (pick < 80) begin
			push_rand(tiflf_pkg::BYTE_IAC);
			push_rand($urandom_range(1) ? tiflf_pkg::BYTE_WILL : tiflf_pkg::BYTE_WONT);
			push_rand(tiflf_pkg::OPT_ECHO);
			n = 3;
		end else if (pick < 92) begin
			push_rand(tiflf_pkg::BYTE_IAC);
			push_rand(8'($urandom_range(255, 0)));
			push_rand(8'($urandom_range(255, 0)));
			n = 3;
		end else begin
			push_rand(8'($urandom_range(255, 0)));
		end
	endtask

	task automatic cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		tiflf_pkg::res_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected item: expected none, got dest %0d byte %0d",
					$time, dest, out_byte);
				fails++;
			end else begin
				w = filtered_q.pop_front();
				cmp_field("dest", w.dest, dest);
				cmp_field("out_byte", w.out_byte, out_byte);
				cmp_field("has_byte", w.has_byte, has_byte);
				cmp_field("line_end", w.line_end, line_end);
				cmp_field("echo_local", w.echo_local, echo_local);
				cmp_field("last", w.last, last);
			end
		end
	end

	// receiver side, with a long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < out_idle_pct);
			end
		end
	end

	initial begin
		cyc = 0;
		while (cyc <= CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int sent;
		int n;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = 8'd0;
		chunk_end    = 1'b0;
		fails        = 0;
		hold_req     = 1'b0;
		in_idle_pct  = 15;
		out_idle_pct = 15;
		m_phase      = tiflf_pkg::PH_TEXT;
		m_cmd        = 8'd0;
		m_cr_held    = 1'b0;
		m_line_open  = 1'b0;
		m_echo       = 1'b1;
		dir_rows = '{
			'{8'h41, 1'b1, 1'b1,
				'{tiflf_pkg::DEST_USER, 8'h41, 1'b1, 1'b1, 1'b1, 1'b1}},
			'{tiflf_pkg::BYTE_NUL, 1'b1, 1'b1,
				'{tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_SUB, 1'b1, 1'b1, 1'b1, 1'b1}},
			'{8'h68, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_CR, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_IAC, 1'b0, 1'b0, '0},
			'{8'h07, 1'b0, 1'b0, '0},
			'{8'h09, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_LF, 1'b0, 1'b1,
				'{tiflf_pkg::DEST_USER, tiflf_pkg::BYTE_LF, 1'b1, 1'b1, 1'b1, 1'b1}},
			'{tiflf_pkg::BYTE_CR, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_NUL, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_CR, 1'b1, 1'b0, '0},
			'{tiflf_pkg::BYTE_IAC, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_WILL, 1'b0, 1'b0, '0},
			'{tiflf_pkg::OPT_ECHO, 1'b0, 1'b0, '0},
			'{8'h78, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_CR, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_IAC, 1'b1, 1'b0, '0},
			'{tiflf_pkg::BYTE_WONT, 1'b0, 1'b0, '0},
			'{tiflf_pkg::OPT_ECHO, 1'b0, 1'b0, '0},
			'{8'h79, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_IAC, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_WILL, 1'b0, 1'b0, '0},
			'{tiflf_pkg::OPT_ECHO, 1'b1, 1'b0, '0},
			'{tiflf_pkg::BYTE_IAC, 1'b0, 1'b0, '0},
			'{tiflf_pkg::BYTE_IAC, 1'b0, 1'b0, '0},
			'{tiflf_pkg::OPT_ECHO, 1'b1, 1'b0, '0},
			'{8'hFE, 1'b1, 1'b1,
				'{tiflf_pkg::DEST_USER, 8'hFE, 1'b1, 1'b1, 1'b0, 1'b1}}
		};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			push_byte(dir_rows[i].b, dir_rows[i].ce, dir_rows[i].typed, dir_rows[i].want);

		// receiver holds off while the sender keeps offering items
		hold_req    = 1'b1;
		in_idle_pct = 0;
		sent = 0;
		while (sent < N_RAND) begin
			if (sent >= 30 && sent < 70) begin
				in_idle_pct  = 15;
				out_idle_pct = 15;
			end else if (sent >= 70 && sent < 100) begin
				in_idle_pct  = 0;
				out_idle_pct = 0;
			end else if (sent >= 100) begin
				in_idle_pct  = 15;
				out_idle_pct = 15;
			end
			rand_piece(n);
			sent += n;
		end
		in_valid = 1'b0;

		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/tiflf_pkg.sv
design/tiflf_decode.sv
design/tiflf_queue.sv
design/telnet_iac_filter_line_framer_top.sv
tb/tb.sv
